### hw/rtl/asp_pkg.sv
// ----------------------------------------------------------------------------
// asp_pkg
// Shared codes, types and helpers for the audio sample width packer.
// ----------------------------------------------------------------------------
package asp_pkg;

  // packing mode codes
  localparam logic [2:0] MODE_16TO8  = 3'd0;
  localparam logic [2:0] MODE_16TO16 = 3'd1;
  localparam logic [2:0] MODE_32TO8  = 3'd2;
  localparam logic [2:0] MODE_32TO16 = 3'd3;
  localparam logic [2:0] MODE_32TO24 = 3'd4;

  // register index of the mode register
  localparam logic REG_PACK_MODE = 1'b0;

  // group record handed from the front to the back
  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] w;
  } group_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // source words per group, zero for an unused mode
  function automatic logic [2:0] group_len(input logic [2:0] mode);
    logic [2:0] len;
    unique case (mode)
      MODE_16TO8:  len = 3'd2;
      MODE_16TO16: len = 3'd1;
      MODE_32TO8:  len = 3'd4;
      MODE_32TO16: len = 3'd2;
      MODE_32TO24: len = 3'd4;
      default:     len = 3'd0;
    endcase
    return len;
  endfunction

endpackage

### hw/rtl/audio_sample_width_packer.sv
// ----------------------------------------------------------------------------
// audio_sample_width_packer
// Packs 32-bit sample buffer words into 32-bit playback FIFO words.
//
//   channel  direction  handshake             payload
//   input    in         in_valid / in_stall   source_word[31:0]
//   output   out        out_valid / out_stall fifo_word[31:0], last_of_group
//   config   in         APB write / read      pack_mode at byte address 0
//
// One source word is taken every cycle unless in_stall is raised; results
// leave at up to one a cycle from a registered output. The item that
// closes a group goes into the group queue and then the output register.
// The two-entry queue sets how far the input runs ahead of a stalled
// output; in 32-to-24 mode a group gives three result beats.
// Reset is synchronous: mode 16-to-16, phase zero, queue and output empty.
// ----------------------------------------------------------------------------
module audio_sample_width_packer (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic [31:0] source_word,
  input  logic        in_valid,
  output logic        in_stall,
  output logic [31:0] fifo_word,
  output logic        last_of_group,
  output logic        out_valid,
  input  logic        out_stall
);

  logic               [2:0] pack_mode;
  logic                     cfg_write;
  logic                     mode_write;
  logic                     q_push;
  logic                     q_pop;
  asp_pkg::group_t          q_wr_data;
  asp_pkg::group_t          q_rd_data;
  asp_pkg::q_status_t       q_status;

  // register port
  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready;
  assign mode_write = cfg_write && (paddr[2] == asp_pkg::REG_PACK_MODE);
  assign prdata     = (paddr[2] == asp_pkg::REG_PACK_MODE) ? {29'd0, pack_mode} : 32'd0;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      pack_mode <= asp_pkg::MODE_16TO16;
    end else if (mode_write) begin
      pack_mode <= pwdata[2:0];
    end
  end

  // front: group collection
  asp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pack_mode   (pack_mode),
    .mode_write  (mode_write),
    .source_word (source_word),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .q_status    (q_status),
    .q_push      (q_push),
    .q_data      (q_wr_data)
  );

  // group queue
  asp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .status  (q_status)
  );

  // back: word packing and output
  asp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .rec           (q_rd_data),
    .q_status      (q_status),
    .q_pop         (q_pop),
    .fifo_word     (fifo_word),
    .last_of_group (last_of_group),
    .out_valid     (out_valid),
    .out_stall     (out_stall)
  );

  // no push into a full queue
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_status.full)
    else $error("group pushed into a full queue");

  // no pop from an empty queue
  assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_status.empty)
    else $error("group popped from an empty queue");

  // only 32-to-24 groups have more than one word
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && pack_mode != asp_pkg::MODE_32TO24) |-> last_of_group)
    else $error("multi-word group outside 32-to-24 mode");

endmodule

### hw/rtl/asp_front.sv
// ----------------------------------------------------------------------------
// asp_front
// Accepts source words, collects a group in the held words and pushes the
// finished group record into the queue.
// ----------------------------------------------------------------------------
module asp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [2:0]          pack_mode,
  input  logic                mode_write,
  input  logic [31:0]         source_word,
  input  logic                in_valid,
  output logic                in_stall,
  input  asp_pkg::q_status_t  q_status,
  output logic                q_push,
  output asp_pkg::group_t     q_data
);

  logic [1:0]  phase;
  logic [1:0]  phase_next;
  logic [31:0] held_words [3];
  logic [2:0]  len;
  logic        completes;
  logic        accept;

  // group length and completion of the group by this item
  assign len       = asp_pkg::group_len(pack_mode);
  assign completes = (len != 3'd0) && (({1'b0, phase} + 3'd1) >= len);
  assign in_stall  = completes && q_status.full;
  assign accept    = in_valid && !in_stall;
  assign q_push    = accept && completes;

  // group record from the held words and the closing item
  assign q_data.mode = pack_mode;
  assign q_data.a    = held_words[0];
  assign q_data.b    = held_words[1];
  assign q_data.c    = held_words[2];
  assign q_data.w    = source_word;

  // next phase
  always_comb begin
    phase_next = phase;
    if (accept) begin
      if (len == 3'd0 || completes) begin
        phase_next = 2'd0;
      end else begin
        phase_next = phase + 2'd1;
      end
    end
  end

  // phase counter, cleared on a mode write
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0;
    end else if (mode_write) begin
      phase <= 2'd0;
    end else begin
      phase <= phase_next;
    end
  end

  // held words, written only by items that open or extend a group
  always_ff @(posedge clk) begin
    if (accept && !completes && len != 3'd0 && phase != 2'd3) begin
      held_words[phase] <= source_word;
    end
  end

endmodule

### hw/rtl/asp_queue.sv
// ----------------------------------------------------------------------------
// asp_queue
// Two-entry queue of group records between the front and the back.
// ----------------------------------------------------------------------------
module asp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  asp_pkg::group_t     wr_data,
  input  logic                pop,
  output asp_pkg::group_t     rd_data,
  output asp_pkg::q_status_t  status
);

  asp_pkg::group_t entries [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign rd_data      = entries[rd_ptr];
  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // record storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

### hw/rtl/asp_back.sv
// ----------------------------------------------------------------------------
// asp_back
// Takes group records from the queue and emits one or three packed words
// through an output register.
// ----------------------------------------------------------------------------
module asp_back (
  input  logic                clk,
  input  logic                rst,
  input  asp_pkg::group_t     rec,
  input  asp_pkg::q_status_t  q_status,
  output logic                q_pop,
  output logic [31:0]         fifo_word,
  output logic                last_of_group,
  output logic                out_valid,
  input  logic                out_stall
);

  logic [1:0]  beat;
  logic        beat_last;
  logic [31:0] word;
  logic        load;

  // output register free to take a new item
  assign load  = !out_valid || !out_stall;
  assign q_pop = load && !q_status.empty && beat_last;

  // packed word for the current beat
  always_comb begin
    word      = rec.w;
    beat_last = 1'b1;
    unique case (rec.mode)
      asp_pkg::MODE_16TO8: begin
        word = {rec.a[31:24], rec.a[15:8], rec.w[31:24], rec.w[15:8]};
      end
      asp_pkg::MODE_16TO16: begin
        word = rec.w;
      end
      asp_pkg::MODE_32TO8: begin
        word = {rec.a[31:24], rec.b[31:24], rec.c[31:24], rec.w[31:24]};
      end
      asp_pkg::MODE_32TO16: begin
        word = {rec.a[31:16], rec.w[31:16]};
      end
      asp_pkg::MODE_32TO24: begin
        beat_last = (beat == 2'd2);
        unique case (beat)
          2'd0:    word = {rec.a[31:8], rec.b[31:24]};
          2'd1:    word = {rec.b[23:8], rec.c[31:16]};
          default: word = {rec.c[15:8], rec.w[31:8]};
        endcase
      end
      default: begin
        word = rec.w;
      end
    endcase
  end

  // beat counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      beat      <= 2'd0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= !q_status.empty;
      if (!q_status.empty) begin
        beat <= beat_last ? 2'd0 : beat + 2'd1;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load && !q_status.empty) begin
      fifo_word     <= word;
      last_of_group <= beat_last;
    end
  end

endmodule
